[hw/rtl/psu_pkg.sv]
`default_nettype none

package psu_pkg;

  // time, angle and alpha fields are fixed at 16 bits
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  // divisor width: shrink duration scaled by 256
  localparam int unsigned DIV_DEN_W = TIME_W + FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL        = 3'd0,
    REG_DRAG         = 3'd1,
    REG_GROW_DUR     = 3'd2,
    REG_GROW_MODE    = 3'd3,
    REG_INIT_SIZE    = 3'd4,
    REG_SHRINK_DUR   = 3'd5,
    REG_SHRINK_SCALE = 3'd6,
    REG_FADE_DUR     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GROW_FROM_ZERO  = 2'd0,
    GROW_FROM_INIT  = 2'd1,
    GROW_FROM_POINT = 2'd2,
    GROW_RESERVED   = 2'd3
  } grow_mode_e;

endpackage

`default_nettype wire

[hw/rtl/psu_div.sv]
`default_nettype none

// restoring divider, one quotient bit per stage, NW stages deep
module psu_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : gen_stage
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [DW:0]   t;
    logic          ge;

    if (k == 0) begin : gen_first
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
    end else begin : gen_next
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
    end

    assign t  = {r_in, n_in[NW-1]};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
        num_q[k] <= {n_in[NW-2:0], 1'b0};
        quo_q[k] <= {q_in[NW-2:0], ge};
        den_q[k] <= d_in;
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

`default_nettype wire

[hw/rtl/psu_kin.sv]
`default_nettype none

// one motion component: accel, drag, then position, six register stages
module psu_kin #(
  parameter int unsigned CB = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [CB-1:0]                vel_i,
  input  wire logic signed [CB-1:0]                pos_i,
  input  wire logic signed [CB-1:0]                acc_i,
  input  wire logic        [psu_pkg::TIME_W-1:0]   drag_i,
  input  wire logic        [psu_pkg::TIME_W-1:0]   dt_i,
  output logic      signed [CB-1:0]                vel_o,
  output logic      signed [CB-1:0]                pos_o
);

  localparam int unsigned TW = psu_pkg::TIME_W;
  localparam int unsigned FW = psu_pkg::FRAC_W;
  localparam int unsigned SW = CB + 2 * TW + 2;
  localparam logic signed [SW-1:0] SMAX = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  function automatic logic signed [CB-1:0] sat_w(input logic signed [SW-1:0] x);
    logic signed [CB-1:0] r;
    if (x > SMAX) r = SMAX[CB-1:0];
    else if (x < SMIN) r = SMIN[CB-1:0];
    else r = x[CB-1:0];
    return r;
  endfunction

  logic signed [CB+TW:0]     pa_q;
  logic        [2*TW-1:0]    dd1_q, dd2_q;
  logic signed [CB-1:0]      v0_q, v1_q, v1b_q, v2_q, v2b_q;
  logic signed [CB-1:0]      p1_q, p2_q, p3_q, p4_q, p5_q;
  logic        [TW-1:0]      dt1_q, dt2_q, dt3_q, dt4_q;
  logic signed [CB+2*TW:0]   pr_q;
  logic signed [CB+TW:0]     pp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: acceleration step and drag factor
      pa_q  <= (CB+TW+1)'(acc_i) * (CB+TW+1)'($signed({1'b0, dt_i}));
      dd1_q <= (2*TW)'(drag_i) * (2*TW)'(dt_i);
      v0_q  <= vel_i;
      p1_q  <= pos_i;
      dt1_q <= dt_i;
      // stage 2: apply acceleration
      v1_q  <= sat_w(SW'(v0_q) + SW'(pa_q >>> FW));
      dd2_q <= dd1_q;
      p2_q  <= p1_q;
      dt2_q <= dt1_q;
      // stage 3: drag product
      pr_q  <= (CB+2*TW+1)'(v1_q) * (CB+2*TW+1)'($signed({1'b0, dd2_q}));
      v1b_q <= v1_q;
      p3_q  <= p2_q;
      dt3_q <= dt2_q;
      // stage 4: apply drag
      v2_q  <= sat_w(SW'(v1b_q) - SW'(pr_q >>> (2 * FW)));
      p4_q  <= p3_q;
      dt4_q <= dt3_q;
      // stage 5: displacement
      pp_q  <= (CB+TW+1)'(v2_q) * (CB+TW+1)'($signed({1'b0, dt4_q}));
      v2b_q <= v2_q;
      p5_q  <= p4_q;
      // stage 6: integrate position
      pos_o <= sat_w(SW'(p5_q) + SW'(pp_q >>> FW));
      vel_o <= v2b_q;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/particle_state_update.sv]
`default_nettype none

// particle_state_update: one fixed point time step for a stream of particles
//
// channels
//   cfg_*    register writes (index, data), always ready; write only while idle
//   s_axis_* particle requests, one full particle state per beat
//   m_axis_* results, tuser carries the alive flag
// the restoring dividers for the size and alpha windows set the depth from
//   request to result, one quotient bit per stage
// throughput: one request per cycle; every stage moves together, so a
//   stalled receiver (m_axis_tready low with a result held) freezes the whole
//   pipe and drops s_axis_tready in the same cycle, nothing is lost or repeated
// reset: all registers read zero (no accel, drag, growth, shrink or fade) and
//   the pipe is emptied; payload registers are not reset
// dead particles (age past lifetime) return the input state with the new age
module particle_state_update #(
  parameter int unsigned COMPONENT_BITS = 16,
  localparam int unsigned CB    = COMPONENT_BITS,
  localparam int unsigned IN_W  = ((96 + 10 * CB + 7) / 8) * 8,
  localparam int unsigned OUT_W = 48 + 8 * CB
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [3*CB-1:0]                 cfg_data_i,
  // tdata lsb up: time_step, age_in, time_to_live, position_in, velocity_in,
  // angle_in, angular_velocity, size_in, full_size, alpha_in, zero pad
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [IN_W-1:0]                 s_axis_tdata,
  // tdata lsb up: age_out, position_out, velocity_out, angle_out, size_out,
  // alpha_out
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [OUT_W-1:0]                     m_axis_tdata,
  // tuser: still_alive
  output logic                                 m_axis_tuser
);

  localparam int unsigned TW  = psu_pkg::TIME_W;
  localparam int unsigned FW  = psu_pkg::FRAC_W;
  localparam int unsigned DW  = psu_pkg::DIV_DEN_W;
  localparam int unsigned NW  = 2 * CB + TW;     // widest dividend (shrink)
  localparam int unsigned GNW = CB + TW + 2;     // signed grow dividend
  localparam int unsigned KD  = NW - 4;          // motion result alignment

  typedef struct packed {
    logic            alive;
    logic [15:0]     age;
    logic [15:0]     ang_new;
    logic [15:0]     ang_in;
    logic [3*CB-1:0] pos;
    logic [3*CB-1:0] vel;
    logic [2*CB-1:0] size;
    logic [2*CB-1:0] full;
    logic [15:0]     alpha;
    logic            grow;
    logic            shrink;
    logic            fade;
    logic [1:0]      gneg;
  } side_t;

  typedef struct packed {
    logic [3*CB-1:0] pos;
    logic [3*CB-1:0] vel;
  } kin_t;

  // ---------------------------------------------------------------- registers
  logic [3*CB-1:0]      acc_q;
  logic [TW-1:0]        drag_q, grow_q, shrink_q, fade_q;
  psu_pkg::grow_mode_e  mode_q;
  logic [2*CB-1:0]      init_q, scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      drag_q   <= '0;
      grow_q   <= '0;
      mode_q   <= psu_pkg::GROW_FROM_ZERO;
      init_q   <= '0;
      shrink_q <= '0;
      scale_q  <= '0;
      fade_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (psu_pkg::cfg_reg_e'(cfg_index_i))
        psu_pkg::REG_ACCEL:        acc_q    <= cfg_data_i;
        psu_pkg::REG_DRAG:         drag_q   <= cfg_data_i[TW-1:0];
        psu_pkg::REG_GROW_DUR:     grow_q   <= cfg_data_i[TW-1:0];
        psu_pkg::REG_GROW_MODE:    mode_q   <= psu_pkg::grow_mode_e'(cfg_data_i[1:0]);
        psu_pkg::REG_INIT_SIZE:    init_q   <= cfg_data_i[2*CB-1:0];
        psu_pkg::REG_SHRINK_DUR:   shrink_q <= cfg_data_i[TW-1:0];
        psu_pkg::REG_SHRINK_SCALE: scale_q  <= cfg_data_i[2*CB-1:0];
        psu_pkg::REG_FADE_DUR:     fade_q   <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- flow control
  // one shared advance: every stage moves when the output slot is free
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ------------------------------------------------------------ field unpack
  logic [TW-1:0]   in_dt, in_age, in_ttl;
  logic [3*CB-1:0] in_pos, in_vel;
  logic [15:0]     in_ang, in_av, in_alpha;
  logic [2*CB-1:0] in_size, in_full;

  assign in_dt    = s_axis_tdata[15:0];
  assign in_age   = s_axis_tdata[31:16];
  assign in_ttl   = s_axis_tdata[47:32];
  assign in_pos   = s_axis_tdata[48 +: 3*CB];
  assign in_vel   = s_axis_tdata[48 + 3*CB +: 3*CB];
  assign in_ang   = s_axis_tdata[48 + 6*CB +: 16];
  assign in_av    = s_axis_tdata[64 + 6*CB +: 16];
  assign in_size  = s_axis_tdata[80 + 6*CB +: 2*CB];
  assign in_full  = s_axis_tdata[80 + 8*CB +: 2*CB];
  assign in_alpha = s_axis_tdata[80 + 10*CB +: 16];

  // ------------------------------------------- stage A: life tests, products
  side_t                sa_d, sa_q, sb_d, sb_q;
  logic                 va_q, vb_q;
  logic [16:0]          age17;
  logic signed [17:0]   age_s, shrink_lim, fade_lim;
  logic signed [CB:0]   gbase [2];
  logic signed [GNW-1:0] gnum_d [2], gnum_a_q [2], gnum_b_q [2];
  logic [CB+TW-1:0]     fdt_d [2], fdt_q [2];
  logic [NW-1:0]        shr_q [2];
  logic signed [32:0]   angp_d, angp_q;
  logic [TW-1:0]        dt_a_q, dt_b_q;

  always_comb begin
    age17      = {1'b0, in_age} + {1'b0, in_dt};
    age_s      = $signed({1'b0, age17});
    shrink_lim = $signed({2'b0, in_ttl}) - $signed({2'b0, shrink_q});
    fade_lim   = $signed({2'b0, in_ttl}) - $signed({2'b0, fade_q});

    for (int i = 0; i < 2; i++) begin
      case (mode_q)
        psu_pkg::GROW_FROM_INIT:
          gbase[i] = $signed({1'b0, in_full[i*CB +: CB]})
                   - $signed({1'b0, init_q[i*CB +: CB]});
        psu_pkg::GROW_FROM_POINT:
          gbase[i] = $signed({1'b0, in_full[CB-1:0]}) - $signed({1'b0, init_q[CB-1:0]});
        default:
          gbase[i] = $signed({1'b0, in_full[i*CB +: CB]});
      endcase
      gnum_d[i] = GNW'(gbase[i]) * GNW'($signed({1'b0, in_dt}));
      fdt_d[i]  = (CB+TW)'(in_full[i*CB +: CB]) * (CB+TW)'(in_dt);
    end
    angp_d = 33'($signed(in_av)) * 33'($signed({1'b0, in_dt}));

    sa_d.alive   = age17 <= {1'b0, in_ttl};
    sa_d.age     = age17[16] ? 16'hFFFF : age17[15:0];
    sa_d.ang_new = in_ang;
    sa_d.ang_in  = in_ang;
    sa_d.pos     = in_pos;
    sa_d.vel     = in_vel;
    sa_d.size    = in_size;
    sa_d.full    = in_full;
    sa_d.alpha   = in_alpha;
    sa_d.grow    = age17 < {1'b0, grow_q};
    sa_d.shrink  = age_s > shrink_lim;
    sa_d.fade    = age_s > fade_lim;
    sa_d.gneg    = {gnum_d[1][GNW-1], gnum_d[0][GNW-1]};
  end

  // ----------------------------------------- stage B: shrink product, angle
  logic signed [33:0] ang_sum;
  logic [15:0]        ang_sat;

  always_comb begin
    ang_sum = 34'($signed(sa_q.ang_in)) + 34'(angp_q >>> FW);
    if (ang_sum > 34'sd32767) ang_sat = 16'h7FFF;
    else if (ang_sum < -34'sd32768) ang_sat = 16'h8000;
    else ang_sat = ang_sum[15:0];
    sb_d         = sa_q;
    sb_d.ang_new = ang_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q   <= sa_d;
      angp_q <= angp_d;
      dt_a_q <= in_dt;
      for (int i = 0; i < 2; i++) begin
        gnum_a_q[i] <= gnum_d[i];
        fdt_q[i]    <= fdt_d[i];
        gnum_b_q[i] <= gnum_a_q[i];
        shr_q[i]    <= NW'(fdt_q[i]) * NW'(scale_q[i*CB +: CB]);
      end
      sb_q   <= sb_d;
      dt_b_q <= dt_a_q;
    end
  end

  // --------------------------------------------------------------- dividers
  // lanes 0 and 1: size x and y (grow or shrink), lane 2: alpha fade
  logic [NW-1:0]  div_num [3];
  logic [DW-1:0]  div_den [3];
  logic [NW-1:0]  div_quo [3];

  always_comb begin
    logic [GNW-1:0] gmag;
    for (int i = 0; i < 2; i++) begin
      // floor of a negative dividend: divide its complement, complement back
      gmag = gnum_b_q[i] ^ {GNW{sb_q.gneg[i]}};
      if (sb_q.grow) begin
        div_num[i] = NW'(gmag[GNW-2:0]);
        div_den[i] = DW'(grow_q);
      end else begin
        div_num[i] = shr_q[i];
        div_den[i] = {shrink_q, {FW{1'b0}}};
      end
    end
    div_num[2] = NW'({dt_b_q, 16'h0000});
    div_den[2] = DW'(fade_q);
  end

  for (genvar d = 0; d < 3; d++) begin : gen_div
    psu_div #(
      .NW(NW),
      .DW(DW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (div_num[d]),
      .den_i (div_den[d]),
      .quo_o (div_quo[d])
    );
  end

  // --------------------------------------------------------- motion lanes
  kin_t kin_w;

  for (genvar c = 0; c < 3; c++) begin : gen_kin
    psu_kin #(
      .CB(CB)
    ) u_kin (
      .clk_i  (clk_i),
      .en_i   (adv),
      .vel_i  ($signed(in_vel[c*CB +: CB])),
      .pos_i  ($signed(in_pos[c*CB +: CB])),
      .acc_i  ($signed(acc_q[c*CB +: CB])),
      .drag_i (drag_q),
      .dt_i   (in_dt),
      .vel_o  (kin_w.vel[c*CB +: CB]),
      .pos_o  (kin_w.pos[c*CB +: CB])
    );
  end

  // ------------------------------------------------------ alignment delays
  side_t side_q [NW];
  logic  vld_q  [NW];
  kin_t  kd_q   [KD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      for (int k = 0; k < NW; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      va_q     <= s_axis_tvalid;
      vb_q     <= va_q;
      vld_q[0] <= vb_q;
      for (int k = 1; k < NW; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= sb_q;
      for (int k = 1; k < NW; k++) side_q[k] <= side_q[k-1];
      kd_q[0] <= kin_w;
      for (int k = 1; k < KD; k++) kd_q[k] <= kd_q[k-1];
    end
  end

  // ------------------------------------------------- final stage: size, alpha
  side_t              fs;
  kin_t               fk;
  logic [2*CB-1:0]    nsize;
  logic [15:0]        nalpha;
  logic [OUT_W-1:0]   out_d;

  assign fs = side_q[NW-1];
  assign fk = kd_q[KD-1];

  always_comb begin
    logic signed [NW+1:0] gd;
    logic signed [NW+1:0] gs;
    logic [CB-1:0]        s;
    logic [CB-1:0]        f;
    for (int i = 0; i < 2; i++) begin
      s  = fs.size[i*CB +: CB];
      f  = fs.full[i*CB +: CB];
      gd = fs.gneg[i] ? ~$signed({2'b00, div_quo[i]}) : $signed({2'b00, div_quo[i]});
      gs = $signed((NW+2)'(s)) + gd;
      if (fs.grow) begin
        if (gs < 0) nsize[i*CB +: CB] = '0;
        else if (gs > $signed((NW+2)'(f))) nsize[i*CB +: CB] = f;
        else nsize[i*CB +: CB] = gs[CB-1:0];
      end else if (fs.shrink) begin
        if (div_quo[i] > NW'(s)) nsize[i*CB +: CB] = '0;
        else nsize[i*CB +: CB] = s - div_quo[i][CB-1:0];
      end else begin
        nsize[i*CB +: CB] = f;
      end
    end

    if (!fs.fade) nalpha = fs.alpha;
    else if (NW'(fs.alpha) > div_quo[2]) nalpha = fs.alpha - div_quo[2][15:0];
    else nalpha = '0;

    if (fs.alive) begin
      out_d = {nalpha, nsize, fs.ang_new, fk.vel, fk.pos, fs.age};
    end else begin
      out_d = {fs.alpha, fs.size, fs.ang_in, fs.vel, fs.pos, fs.age};
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= vld_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= out_d;
      m_axis_tuser <= fs.alive;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/psu_checker.sv]
`default_nettype none

module psu_checker #(
  parameter int unsigned COMPONENT_BITS = 16,
  localparam int unsigned CB    = COMPONENT_BITS,
  localparam int unsigned OUT_W = 48 + 8 * CB
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [OUT_W-1:0]              m_axis_tdata,
  input wire logic                          m_axis_tuser
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("held result changed");

  // empty output slot never blocks a request
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request blocked with empty output");

  // a result taken frees the pipe in the same cycle
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("request blocked while result taken");

  // a stalled result freezes intake
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken during output stall");

endmodule

bind particle_state_update psu_checker #(
  .COMPONENT_BITS(COMPONENT_BITS)
) u_psu_checker (.*);

`default_nettype wire
